### rtl/svlp_pkg.sv
// ----------------------------------------------------------------------------
// svlp_pkg
// Shared widths, constants, the queue entry type and helper functions of the
// 2x oversampled state-variable lowpass.
// ----------------------------------------------------------------------------
package svlp_pkg;

	localparam int SAMPLE_WIDTH = 24;
	localparam int COEF_WIDTH   = 18;
	localparam int RATE_WIDTH   = 18;
	localparam int CUT_WIDTH    = 17;
	localparam int RES_WIDTH    = 16;
	localparam int DAMP_WIDTH   = 17;
	// working width of the filter states between the two passes
	localparam int WORK_WIDTH   = SAMPLE_WIDTH + 8;
	localparam int MULC_WIDTH   = ((COEF_WIDTH > DAMP_WIDTH) ? COEF_WIDTH : DAMP_WIDTH) + 1;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [RATE_WIDTH-1:0] RATE_FLOOR = RATE_WIDTH'(1000);
	localparam logic [RATE_WIDTH-1:0] RATE_RESET = RATE_WIDTH'(48000);
	localparam logic [CUT_WIDTH-1:0]  CUT_MIN    = CUT_WIDTH'(20);
	localparam logic [31:0]           RATIO_MAX  = 32'd1846835937;
	localparam logic [31:0]           PI_Q30     = 32'd3373259426;
	localparam logic [RES_WIDTH-1:0]  Q_MAX      = RES_WIDTH'(62915);
	localparam logic [DAMP_WIDTH-1:0] ONE_Q16    = DAMP_WIDTH'(65536);
	localparam logic [COEF_WIDTH-1:0] FMAX       = COEF_WIDTH'((95 * (2 ** COEF_WIDTH)) / 100);

	// one queued job: sample, coefficient and damping
	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] x;
		logic [COEF_WIDTH-1:0]          f;
		logic [DAMP_WIDTH-1:0]          damp;
	} job_t;

	// taylor divisor (2k)(2k+1) of series term k
	function automatic logic [6:0] sin_div(input logic [2:0] k);
		logic [6:0] d;
		unique case (k)
			3'd1:    d = 7'd6;
			3'd2:    d = 7'd20;
			3'd3:    d = 7'd42;
			3'd4:    d = 7'd72;
			3'd5:    d = 7'd110;
			default: d = 7'd1;
		endcase
		return d;
	endfunction

	// floor(2^32 / divisor) of series term k
	function automatic logic [31:0] sin_recip(input logic [2:0] k);
		logic [31:0] m;
		unique case (k)
			3'd1:    m = 32'd715827882;
			3'd2:    m = 32'd214748364;
			3'd3:    m = 32'd102261126;
			3'd4:    m = 32'd59652323;
			3'd5:    m = 32'd39045157;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	// saturate a working state to the sample range
	function automatic logic signed [SAMPLE_WIDTH-1:0] clamp_state(
		input logic signed [WORK_WIDTH-1:0] v);
		logic signed [WORK_WIDTH-1:0] hi;
		logic signed [WORK_WIDTH-1:0] lo;
		logic signed [SAMPLE_WIDTH-1:0] r;
		hi = WORK_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
		lo = -hi - WORK_WIDTH'(1);
		if (v > hi)
			r = hi[SAMPLE_WIDTH-1:0];
		else if (v < lo)
			r = lo[SAMPLE_WIDTH-1:0];
		else
			r = v[SAMPLE_WIDTH-1:0];
		return r;
	endfunction

endpackage

### rtl/svlp_front.sv
// ----------------------------------------------------------------------------
// svlp_front
// Takes input items, holds the sample rate register, works out the filter
// coefficient (restoring division for the ratio, then x = pi*r and taylor
// sine on one shared multiplier) and pushes the job into the queue.
// ----------------------------------------------------------------------------
module svlp_front import svlp_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [RATE_WIDTH-1:0]          cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
	input  logic [CUT_WIDTH-1:0]           cutoff_hz,
	input  logic [RES_WIDTH-1:0]           resonance,
	output logic                           push,
	output job_t                           push_job,
	input  logic                           full
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIV  = 4'd1;
	localparam logic [3:0] ST_MPI  = 4'd2;
	localparam logic [3:0] ST_SQ   = 4'd3;
	localparam logic [3:0] ST_X2   = 4'd4;
	localparam logic [3:0] ST_TM   = 4'd5;
	localparam logic [3:0] ST_RM   = 4'd6;
	localparam logic [3:0] ST_CORR = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;
	localparam logic [3:0] ST_PUSH = 4'd9;

	logic [3:0]                    state_q;
	logic [RATE_WIDTH-1:0]         rate_q;
	logic [RATE_WIDTH-1:0]         fs_q;
	logic [RATE_WIDTH-1:0]         rem_q;
	logic [31:0]                   quo_q;
	logic [3:0]                    cnt_q;
	logic                          sat_q;
	logic signed [SAMPLE_WIDTH-1:0] smp_q;
	logic [DAMP_WIDTH-1:0]         damp_q;
	logic [31:0]                   x2_q;
	logic [31:0]                   term_q;
	logic [31:0]                   p_q;
	logic signed [33:0]            sum_q;
	logic [2:0]                    k_q;
	logic [63:0]                   prod_q;
	logic [COEF_WIDTH-1:0]         f_q;

	logic                          accept;
	logic [CUT_WIDTH-1:0]          fcc;
	logic [RATE_WIDTH-1:0]         fs_in;
	logic                          sat_in;
	logic [RES_WIDTH-1:0]          res_c;
	logic [RATE_WIDTH+1:0]         r1;
	logic                          ge1;
	logic [RATE_WIDTH-1:0]         r1n;
	logic [RATE_WIDTH+1:0]         r2;
	logic                          ge2;
	logic [RATE_WIDTH-1:0]         r2n;
	logic [31:0]                   mul_a;
	logic [31:0]                   mul_b;
	logic [31:0]                   qe;
	logic [6:0]                    dk;
	logic [39:0]                   rem_t;
	logic [31:0]                   tv;
	logic [33:0]                   s_pos;
	logic [34:0]                   fw;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign push      = (state_q == ST_PUSH) && !full;

	assign push_job.x    = smp_q;
	assign push_job.f    = f_q;
	assign push_job.damp = damp_q;

	// input clamps and the upper cutoff test
	always_comb begin
		fcc    = (cutoff_hz < CUT_MIN) ? CUT_MIN : cutoff_hz;
		fs_in  = (rate_q < RATE_FLOOR) ? RATE_FLOOR : rate_q;
		sat_in = (25'(fcc) * 25'd100) >= (25'(fs_in) * 25'd43);
		res_c  = (resonance > Q_MAX) ? Q_MAX : resonance;
	end

	// two restoring division steps per cycle
	always_comb begin
		r1  = {2'b0, rem_q} << 1;
		ge1 = r1 >= {2'b0, fs_q};
		r1n = ge1 ? RATE_WIDTH'(r1 - {2'b0, fs_q}) : RATE_WIDTH'(r1);
		r2  = {2'b0, r1n} << 1;
		ge2 = r2 >= {2'b0, fs_q};
		r2n = ge2 ? RATE_WIDTH'(r2 - {2'b0, fs_q}) : RATE_WIDTH'(r2);
	end

	// shared multiplier operands
	always_comb begin
		unique case (state_q)
			ST_MPI: begin
				mul_a = sat_q ? RATIO_MAX : quo_q;
				mul_b = PI_Q30;
			end
			ST_SQ: begin
				mul_a = prod_q[63:32];
				mul_b = prod_q[63:32];
			end
			ST_TM: begin
				mul_a = term_q;
				mul_b = x2_q;
			end
			ST_RM: begin
				mul_a = prod_q[61:30];
				mul_b = sin_recip(k_q);
			end
			default: begin
				mul_a = term_q;
				mul_b = x2_q;
			end
		endcase
	end

	// reciprocal quotient correction and coefficient scaling
	always_comb begin
		qe    = prod_q[63:32];
		dk    = sin_div(k_q);
		rem_t = {8'b0, p_q} - (40'(qe) * 40'(dk));
		tv    = (rem_t >= 40'(dk)) ? qe + 32'd1 : qe;
		s_pos = (sum_q < 0) ? 34'd0 : 34'(sum_q);
		fw    = ({1'b0, s_pos} << 1) >> (30 - COEF_WIDTH);
	end

	// sample rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rate_q <= RATE_RESET;
		else if (cfg_valid && cfg_ready)
			rate_q <= cfg_data;
	end

	// coefficient sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) begin
					state_q <= ST_DIV;
					cnt_q   <= '0;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15)
						state_q <= ST_MPI;
				end
				ST_MPI:  state_q <= ST_SQ;
				ST_SQ:   state_q <= ST_X2;
				ST_X2: begin
					k_q     <= 3'd1;
					state_q <= ST_TM;
				end
				ST_TM:   state_q <= ST_RM;
				ST_RM:   state_q <= ST_CORR;
				ST_CORR: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd5)
						state_q <= ST_DONE;
					else
						state_q <= ST_TM;
				end
				ST_DONE: state_q <= ST_PUSH;
				ST_PUSH: if (!full) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			fs_q   <= fs_in;
			sat_q  <= sat_in;
			rem_q  <= sat_in ? '0 : RATE_WIDTH'(fcc);
			quo_q  <= '0;
			smp_q  <= in_sample;
			damp_q <= ONE_Q16 - DAMP_WIDTH'(res_c);
		end
		if (state_q == ST_DIV) begin
			rem_q <= r2n;
			quo_q <= {quo_q[29:0], ge1, ge2};
		end
		if (state_q == ST_MPI || state_q == ST_SQ || state_q == ST_TM || state_q == ST_RM)
			prod_q <= 64'(mul_a) * 64'(mul_b);
		if (state_q == ST_SQ) begin
			term_q <= prod_q[63:32];
			sum_q  <= $signed({2'b0, prod_q[63:32]});
		end
		if (state_q == ST_X2)
			x2_q <= prod_q[61:30];
		if (state_q == ST_RM)
			p_q <= prod_q[61:30];
		if (state_q == ST_CORR) begin
			term_q <= tv;
			if (k_q[0])
				sum_q <= sum_q - $signed({2'b0, tv});
			else
				sum_q <= sum_q + $signed({2'b0, tv});
		end
		if (state_q == ST_DONE)
			f_q <= (fw > 35'(FMAX)) ? FMAX : fw[COEF_WIDTH-1:0];
	end

`ifndef SYNTHESIS
	// division remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < fs_q))
		else $error("divider remainder out of range");
	// a pushed coefficient never exceeds its clamp
	a_coef_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_job.f <= FMAX))
		else $error("coefficient above clamp");
`endif

endmodule

### rtl/svlp_fifo.sv
// ----------------------------------------------------------------------------
// svlp_fifo
// Short job queue between the coefficient front end and the filter back end.
// ----------------------------------------------------------------------------
module svlp_fifo import svlp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t pop_job,
	output logic full,
	output logic empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full    = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue pop while empty");
`endif

endmodule

### rtl/svlp_back.sv
// ----------------------------------------------------------------------------
// svlp_back
// Runs the two filter passes of a job on one multiplier, clamps the states
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module svlp_back import svlp_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	output logic                           pop,
	input  job_t                           pop_job,
	input  logic                           empty,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] low_out
);

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_HM   = 3'd1;
	localparam logic [2:0] B_HI   = 3'd2;
	localparam logic [2:0] B_FH   = 3'd3;
	localparam logic [2:0] B_BA   = 3'd4;
	localparam logic [2:0] B_FB   = 3'd5;
	localparam logic [2:0] B_LO   = 3'd6;
	localparam logic [2:0] B_OUT  = 3'd7;

	localparam int PROD_WIDTH = MULC_WIDTH + WORK_WIDTH;

	logic [2:0]                     state_q;
	logic                           pass_q;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] low_out_q;
	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic [COEF_WIDTH-1:0]          f_q;
	logic [DAMP_WIDTH-1:0]          damp_q;
	logic signed [WORK_WIDTH-1:0]   low_q;
	logic signed [WORK_WIDTH-1:0]   band_q;
	logic signed [WORK_WIDTH-1:0]   high_q;
	logic signed [PROD_WIDTH-1:0]   prod_q;

	logic signed [MULC_WIDTH-1:0]   mc;
	logic signed [WORK_WIDTH-1:0]   mv;
	logic signed [PROD_WIDTH-1:0]   prod_dsh;
	logic signed [PROD_WIDTH-1:0]   prod_fsh;
	logic                           out_free;
	logic signed [SAMPLE_WIDTH-1:0] low_c;
	logic signed [SAMPLE_WIDTH-1:0] band_c;

	assign pop       = (state_q == B_IDLE) && !empty;
	assign out_valid = out_valid_q;
	assign low_out   = low_out_q;
	assign out_free  = !out_valid_q || out_ready;

	// multiplier operands (coefficients zero extended), shifts and clamps
	always_comb begin
		mc = (state_q == B_HM) ? $signed(MULC_WIDTH'(damp_q)) : $signed(MULC_WIDTH'(f_q));
		mv = (state_q == B_FH) ? high_q : band_q;
		prod_dsh = prod_q >>> 16;
		prod_fsh = prod_q >>> (COEF_WIDTH + 1);
		low_c    = clamp_state(low_q);
		band_c   = clamp_state(band_q);
	end

	// pass sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			pass_q  <= 1'b0;
			low_q   <= '0;
			band_q  <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: if (pop) begin
					pass_q  <= 1'b0;
					state_q <= B_HM;
				end
				B_HM: state_q <= B_HI;
				B_HI: state_q <= B_FH;
				B_FH: state_q <= B_BA;
				B_BA: begin
					band_q  <= band_q + WORK_WIDTH'(prod_fsh);
					state_q <= B_FB;
				end
				B_FB: state_q <= B_LO;
				B_LO: begin
					low_q <= low_q + WORK_WIDTH'(prod_fsh);
					if (pass_q)
						state_q <= B_OUT;
					else begin
						pass_q  <= 1'b1;
						state_q <= B_HM;
					end
				end
				B_OUT: if (out_free) begin
					low_q   <= WORK_WIDTH'(low_c);
					band_q  <= WORK_WIDTH'(band_c);
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == B_OUT && out_free)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// job latch, product, high register and output sample
	always_ff @(posedge clk) begin
		if (pop) begin
			x_q    <= pop_job.x;
			f_q    <= pop_job.f;
			damp_q <= pop_job.damp;
		end
		if (state_q == B_HM || state_q == B_FH || state_q == B_FB)
			prod_q <= PROD_WIDTH'(mc) * PROD_WIDTH'(mv);
		if (state_q == B_HI)
			high_q <= WORK_WIDTH'(x_q) - low_q - WORK_WIDTH'(prod_dsh);
		if (state_q == B_OUT && out_free)
			low_out_q <= low_c;
	end

`ifndef SYNTHESIS
	// a result is only loaded after the second pass
	a_two_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_OUT) |-> pass_q)
		else $error("result before second pass");
`endif

endmodule

### rtl/state_variable_lowpass_2x_unit.sv
// ----------------------------------------------------------------------------
// state_variable_lowpass_2x_unit
// Resonant state-variable lowpass run twice per sample, fixed point.
// ----------------------------------------------------------------------------
// Use:
// - input channel (in_valid/in_ready) takes one sample in Q3.20, a cutoff in
//   whole Hz and a resonance in Q0.16 per transfer
// - output channel (out_valid/out_ready) gives one lowpass sample per input
// - cfg channel (cfg_valid/cfg_ready/cfg_data) writes the sample rate in Hz;
//   write it only while no sample is in flight; cfg_ready is always high
// Flow:
// - the front end takes one item at a time: two-bit restoring division
//   for fc/fs, then the taylor sine on one shared multiplier; it takes
//   no new item until its job is pushed into the queue
// - a two-entry queue follows, then the back end runs both passes on its
//   own multiplier, then clamps the states and loads the output register
// - while the receiver stalls, the held result waits in the output register,
//   the back end holds its finished job, the queue fills, and the front end
//   stops taking items once its finished job cannot be pushed
// Reset clears the filter states, the queue and the output valid flag and sets
// the sample rate to 48000 Hz.
// ----------------------------------------------------------------------------
module state_variable_lowpass_2x_unit import svlp_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [RATE_WIDTH-1:0]          cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
	input  logic [CUT_WIDTH-1:0]           cutoff_hz,
	input  logic [RES_WIDTH-1:0]           resonance,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] low_out
);

	logic push;
	logic pop;
	logic full;
	logic empty;
	job_t push_job;
	job_t pop_job;

	// coefficient front end
	svlp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_sample (in_sample),
		.cutoff_hz (cutoff_hz),
		.resonance (resonance),
		.push      (push),
		.push_job  (push_job),
		.full      (full)
	);

	// job queue
	svlp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.full     (full),
		.empty    (empty)
	);

	// filter back end
	svlp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (pop),
		.pop_job   (pop_job),
		.empty     (empty),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.low_out   (low_out)
	);

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 2x oversampled state-variable lowpass: a
// directed table and random samples are driven with random idling on both
// sides, and every output sample is compared with a local fixed-point filter.
// ----------------------------------------------------------------------------
module testbench import svlp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int N_RANDOM    = 480;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [RATE_WIDTH-1:0]          cfg_data;
	logic                           in_valid;
	logic                           in_ready;
	logic signed [SAMPLE_WIDTH-1:0] in_sample;
	logic [CUT_WIDTH-1:0]           cutoff_hz;
	logic [RES_WIDTH-1:0]           resonance;
	logic                           out_valid;
	logic                           out_ready;
	logic signed [SAMPLE_WIDTH-1:0] low_out;

	state_variable_lowpass_2x_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_sample(in_sample),
		.cutoff_hz(cutoff_hz), .resonance(resonance),
		.out_valid(out_valid), .out_ready(out_ready), .low_out(low_out)
	);

	// one directed row; check_low set when the output is known up front
	typedef struct {
		logic signed [SAMPLE_WIDTH-1:0] smp;
		logic [CUT_WIDTH-1:0]           cut;
		logic [RES_WIDTH-1:0]           res;
		bit                             check_low;
		logic signed [SAMPLE_WIDTH-1:0] low;
	} row_t;

	// filter model state and rate register
	longint unsigned               model_rate;
	longint                        model_low;
	longint                        model_band;
	logic signed [SAMPLE_WIDTH-1:0] low_queue[$];
	int  errors;
	int  cycles;
	int  outputs_seen;
	bit  quiet;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// floor division by a power of two
	function automatic longint fshift(input longint v, input int s);
		return v >>> s;
	endfunction

	// filter coefficient for a cutoff at the current rate
	function automatic longint unsigned lp_coef(input longint unsigned fc);
		longint unsigned fs, r, x, x2, term, f;
		longint sum;
		fs = (model_rate < 1000) ? 1000 : model_rate;
		if (fc < 20)
			fc = 20;
		if (fc * 100 >= fs * 43)
			r = 64'd1846835937;
		else
			r = (fc << 32) / fs;
		x = (r * 64'd3373259426) >> 32;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int k = 1; k <= 5; k++) begin
			term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
			if (k % 2 == 1)
				sum -= longint'(term);
			else
				sum += longint'(term);
		end
		if (sum < 0)
			sum = 0;
		f = (longint'(sum) * 2) >> (30 - COEF_WIDTH);
		if (f > longint'(FMAX))
			f = FMAX;
		return f;
	endfunction

	function automatic longint sat_state(input longint v);
		longint hi;
		hi = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
		if (v > hi)
			return hi;
		if (v < -hi - 1)
			return -hi - 1;
		return v;
	endfunction

	// advance the filter by one sample, return the low output
	function automatic logic signed [SAMPLE_WIDTH-1:0] lowpass_step(
		input logic signed [SAMPLE_WIDTH-1:0] smp,
		input logic [CUT_WIDTH-1:0] cut, input logic [RES_WIDTH-1:0] res);
		longint f, damp, x, high;
		f = longint'(lp_coef(cut));
		damp = 65536 - ((res > 62915) ? 62915 : longint'(res));
		x = smp;
		for (int p = 0; p < 2; p++) begin
			high = x - model_low - fshift(damp * model_band, 16);
			model_band += fshift(f * high, COEF_WIDTH + 1);
			model_low += fshift(f * model_band, COEF_WIDTH + 1);
		end
		model_band = sat_state(model_band);
		model_low = sat_state(model_low);
		return model_low[SAMPLE_WIDTH-1:0];
	endfunction

	// random gap before a transfer, valid low while idling
	task automatic idle_burst();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
	endtask

	// one sample transfer; expected output pushed at acceptance
	task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] smp,
		input logic [CUT_WIDTH-1:0] cut, input logic [RES_WIDTH-1:0] res,
		input bit fixed, input logic signed [SAMPLE_WIDTH-1:0] low);
		logic signed [SAMPLE_WIDTH-1:0] exp_low;
		idle_burst();
		in_valid <= 1'b1;
		in_sample <= smp;
		cutoff_hz <= cut;
		resonance <= res;
		do @(posedge clk); while (!in_ready);
		exp_low = lowpass_step(smp, cut, res);
		low_queue.push_back(fixed ? low : exp_low);
		@(negedge clk);
	endtask

	// drain, let the pipeline settle, then write the rate register
	task automatic write_rate(input logic [RATE_WIDTH-1:0] rate);
		in_valid <= 1'b0;
		wait (low_queue.size() == 0);
		repeat (60) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= rate;
		do @(posedge clk); while (!cfg_ready);
		model_rate = rate;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// output side: random stall bursts, compare each transfer
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			outputs_seen++;
			if (low_queue.size() == 0) begin
				errors++;
				$error("unexpected low_out transfer, actual %0d", low_out);
			end else begin
				if (low_out !== low_queue[0]) begin
					errors++;
					$error("low_out mismatch: expected %0d actual %0d",
						low_queue[0], low_out);
				end
				void'(low_queue.pop_front());
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		logic [RATE_WIDTH-1:0] rates[5];
		int  mode;
		logic signed [SAMPLE_WIDTH-1:0] smp;
		errors = 0;
		cycles = 0;
		outputs_seen = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_sample = '0;
		cutoff_hz = '0;
		resonance = '0;
		model_rate = 48000;
		model_low = 0;
		model_band = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table: zero input, extremes, clamps of cutoff and resonance
		rows = '{
			'{24'sd0, 17'd1000, 16'd0, 1'b1, 24'sd0},
			'{24'sd0, 17'd0, 16'hFFFF, 1'b1, 24'sd0},
			'{24'sh7FFFFF, 17'd0, 16'd0, 1'b0, 24'sd0},
			'{24'sh7FFFFF, 17'd19, 16'd62915, 1'b0, 24'sd0},
			'{24'sh7FFFFF, 17'd20, 16'd62916, 1'b0, 24'sd0},
			'{24'sh7FFFFF, 17'h1FFFF, 16'hFFFF, 1'b0, 24'sd0},
			'{24'sh7FFFFF, 17'd20640, 16'hFFFF, 1'b0, 24'sd0},
			'{24'sh7FFFFF, 17'd20639, 16'hFFFF, 1'b0, 24'sd0},
			'{24'sh800000, 17'h1FFFF, 16'hFFFF, 1'b0, 24'sd0},
			'{24'sh800000, 17'h1FFFF, 16'hFFFF, 1'b0, 24'sd0},
			'{24'sh7FFFFF, 17'h1FFFF, 16'hFFFF, 1'b0, 24'sd0},
			'{24'sh800000, 17'd5000, 16'd32768, 1'b0, 24'sd0},
			'{24'sd1048576, 17'd1000, 16'd0, 1'b0, 24'sd0},
			'{24'sh555555, 17'h15555, 16'h5555, 1'b0, 24'sd0},
			'{24'shAAAAAA, 17'h0AAAA, 16'hAAAA, 1'b0, 24'sd0}
		};
		foreach (rows[i])
			send_sample(rows[i].smp, rows[i].cut, rows[i].res,
				rows[i].check_low, rows[i].low);

		// low rate floor, extremes, then random phases at several rates
		rates = '{18'd0, 18'd999, 18'h3FFFF, 18'd1000, 18'd48000};
		for (int ph = 0; ph < 5; ph++) begin
			write_rate(rates[ph]);
			if (ph == 2)
				wait (low_queue.size() == 0);
			quiet = (ph == 4);
			for (int n = 0; n < N_RANDOM / 5; n++) begin
				mode = $urandom_range(0, 9);
				// mostly musical levels, sometimes full scale to hit the clamps
				if (mode < 7)
					smp = $signed(24'($urandom_range(0, 2097151))) - 24'sd1048576;
				else
					smp = 24'($urandom);
				send_sample(smp,
					(mode == 9) ? 17'($urandom) : 17'($urandom_range(0, 25000)),
					16'($urandom), 1'b0, 24'sd0);
			end
		end
		in_valid <= 1'b0;

		wait (low_queue.size() == 0);
		repeat (100) @(negedge clk);
		$display("covered %0d output samples over five sample rates incl. floor and max",
			outputs_seen);
		if (errors == 0 && low_queue.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### sim.f
rtl/svlp_pkg.sv
rtl/svlp_front.sv
rtl/svlp_fifo.sv
rtl/svlp_back.sv
rtl/state_variable_lowpass_2x_unit.sv
dv/testbench.sv
